@@ design/rgb_fade_blink_controller_defines.svh @@
// Assertion macros shared by the controller's checker.
`ifndef RGB_FADE_BLINK_CONTROLLER_DEFINES_SVH
`define RGB_FADE_BLINK_CONTROLLER_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define RFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rfb_pkg.sv @@
// Constants, request codes and state type of the RGB fade and blink controller.
`default_nettype none
package rfb_pkg;

   localparam int TICK_BITS        = 32;
   localparam int HEARTBEAT_PERIOD = 1000;
   localparam int LEVEL_BITS       = 16;
   localparam int CODE_BITS        = 8;
   localparam int NUM_CH           = 3;
   localparam int HB_BITS          = $clog2(HEARTBEAT_PERIOD);
   localparam int CNT_BITS         = $clog2(TICK_BITS);
   localparam int REQ_TDATA_BITS   = 40;
   localparam int RSP_TDATA_BITS   = 56;
   localparam int RSP_PAD_BITS     = RSP_TDATA_BITS - NUM_CH * LEVEL_BITS - 2;

   localparam logic [LEVEL_BITS-1:0] DEFAULT_FADE_STEP = LEVEL_BITS'(256);
   localparam logic [HB_BITS-1:0]    HB_LAST           = HB_BITS'(HEARTBEAT_PERIOD - 1);
   localparam logic [HB_BITS-1:0]    HB_OFF_AT         = HB_BITS'(10);

   // Kind of input word, carried on tuser
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Request codes
   localparam logic [CODE_BITS-1:0] REQ_ALL_OFF    = 8'd0;
   localparam logic [CODE_BITS-1:0] REQ_COMMIT     = 8'd1;
   localparam logic [CODE_BITS-1:0] REQ_FLAG       = 8'd2;
   localparam logic [CODE_BITS-1:0] REQ_RED        = 8'd3;
   localparam logic [CODE_BITS-1:0] REQ_GREEN      = 8'd4;
   localparam logic [CODE_BITS-1:0] REQ_BLUE       = 8'd5;
   localparam logic [CODE_BITS-1:0] REQ_GOAL_RED   = 8'd6;
   localparam logic [CODE_BITS-1:0] REQ_GOAL_GREEN = 8'd7;
   localparam logic [CODE_BITS-1:0] REQ_GOAL_BLUE  = 8'd8;
   localparam logic [CODE_BITS-1:0] REQ_STEP       = 8'd9;
   localparam logic [CODE_BITS-1:0] REQ_BLINK      = 8'd10;

   // Response word bit positions
   localparam int RSP_WRITE_BIT  = NUM_CH * LEVEL_BITS;
   localparam int RSP_STATUS_BIT = NUM_CH * LEVEL_BITS + 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage
`default_nettype wire

@@ design/rgb_fade_blink_controller.sv @@
// RGB fade and blink controller: request decode, fading, blink and heartbeat.
// A request word gives its response word in the cycle after acceptance;
//   a tick word passes through S_RUN and then S_DONE, which registers its response word.
// Words are taken one at a time; a tick occupies the block through the bit-serial
//   remainder of the tick count by the blink period, one bit per cycle.
// Reset (synchronous, active high): levels and goals 0, fade step 256, blink off,
//   flags and tick count 0, no response pending.
`default_nettype none
module rgb_fade_blink_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] request_code, [23:8] request_value, [39:24] request_index
   input  logic [rfb_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   // [0] operation
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] red_out, [31:16] green_out, [47:32] blue_out, [48] rgb_write,
   // [49] status_led, [55:50] zero
   output logic [rfb_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import rfb_pkg::*;

   // Control state
   state_type                   state_ff, state_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Architectural state
   logic [LEVEL_BITS-1:0]       level_ff [NUM_CH];
   logic [LEVEL_BITS-1:0]       level_in [NUM_CH];
   logic [LEVEL_BITS-1:0]       goal_ff  [NUM_CH];
   logic [LEVEL_BITS-1:0]       goal_in  [NUM_CH];
   logic [LEVEL_BITS-1:0]       step_ff, step_in;
   logic [LEVEL_BITS-1:0]       on_time_ff, on_time_in;
   logic [LEVEL_BITS-1:0]       length_ff, length_in;
   logic                        flag_ff, flag_in;
   logic                        status_ff, status_in;
   logic [TICK_BITS-1:0]        tick_ff, tick_in;
   logic [HB_BITS-1:0]          hb_ff, hb_in;

   // Tick working registers
   logic [LEVEL_BITS-1:0]       mag_ff   [NUM_CH];
   logic [LEVEL_BITS-1:0]       mag_in   [NUM_CH];
   logic [LEVEL_BITS-1:0]       delta_ff [NUM_CH];
   logic [LEVEL_BITS-1:0]       delta_in [NUM_CH];
   logic [NUM_CH-1:0]           up_ff, up_in;
   logic                        moved_ff, moved_in;
   logic [TICK_BITS-1:0]        div_ff, div_in;
   logic [LEVEL_BITS-1:0]       rem_ff, rem_in;
   logic [RSP_TDATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                        space;
   logic                        accept;
   logic [CODE_BITS-1:0]        code;
   logic [LEVEL_BITS-1:0]       value;
   logic [LEVEL_BITS-1:0]       index;
   logic [TICK_BITS-1:0]        tick_next;
   logic [HB_BITS-1:0]          hb_next;

   // The output register is free now or is emptied at this edge
   assign space      = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && space;
   assign accept     = req_tvalid && req_tready;

   assign code  = req_tdata[CODE_BITS-1:0];
   assign value = req_tdata[CODE_BITS+LEVEL_BITS-1:CODE_BITS];
   assign index = req_tdata[CODE_BITS+2*LEVEL_BITS-1:CODE_BITS+LEVEL_BITS];

   assign tick_next = tick_ff + 1'b1;

   // Track tick count modulo the heartbeat period; restart it where the count wraps
   always_comb begin
      if (tick_next == '0) begin
         hb_next = '0;
      end else if (hb_ff == HB_LAST) begin
         hb_next = '0;
      end else begin
         hb_next = hb_ff + 1'b1;
      end
   end

   always_comb begin : next_state
      logic                      write_v;
      logic                      blank_v;
      logic [LEVEL_BITS:0]       sub_v;
      logic [LEVEL_BITS:0]       trial_v;
      logic [LEVEL_BITS+1:0]     diff_v;
      logic [LEVEL_BITS-1:0]     out_v [NUM_CH];

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      level_in     = level_ff;
      goal_in      = goal_ff;
      step_in      = step_ff;
      on_time_in   = on_time_ff;
      length_in    = length_ff;
      flag_in      = flag_ff;
      status_in    = status_ff;
      tick_in      = tick_ff;
      hb_in        = hb_ff;
      mag_in       = mag_ff;
      delta_in     = delta_ff;
      up_in        = up_ff;
      moved_in     = moved_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      write_v      = 1'b0;
      blank_v      = 1'b0;
      sub_v        = '0;
      trial_v      = '0;
      diff_v       = '0;
      out_v        = level_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser[0] == OP_TICK)) begin
               // Advance the tick count and heartbeat, latch distance to each goal
               tick_in = tick_next;
               hb_in   = hb_next;
               if (hb_next == '0) begin
                  status_in = 1'b1;
               end else if (hb_next == HB_OFF_AT) begin
                  status_in = 1'b0;
               end
               for (int i = 0; i < NUM_CH; i++) begin
                  sub_v = {1'b0, goal_ff[i]} - {1'b0, level_ff[i]};
                  if (sub_v[LEVEL_BITS]) begin
                     up_in[i]  = 1'b0;
                     mag_in[i] = level_ff[i] - goal_ff[i];
                  end else begin
                     up_in[i]  = 1'b1;
                     mag_in[i] = sub_v[LEVEL_BITS-1:0];
                  end
               end
               div_in   = tick_next;
               rem_in   = '0;
               moved_in = 1'b0;
               cnt_in   = CNT_BITS'(TICK_BITS - 1);
               state_in = S_RUN;
            end else if (accept) begin
               case (code)
                  REQ_ALL_OFF: begin
                     for (int i = 0; i < NUM_CH; i++) begin
                        level_in[i] = '0;
                        goal_in[i]  = '0;
                     end
                     flag_in   = 1'b0;
                     status_in = 1'b0;
                     write_v   = 1'b1;
                  end
                  REQ_COMMIT: begin
                     status_in = flag_ff;
                     goal_in   = level_ff;
                     write_v   = 1'b1;
                  end
                  REQ_FLAG: begin
                     flag_in = (value != '0);
                  end
                  REQ_RED: begin
                     level_in[0] = value;
                     goal_in     = level_in;
                  end
                  REQ_GREEN: begin
                     level_in[1] = value;
                     goal_in     = level_in;
                  end
                  REQ_BLUE: begin
                     level_in[2] = value;
                     goal_in     = level_in;
                  end
                  REQ_GOAL_RED: begin
                     goal_in[0] = value;
                  end
                  REQ_GOAL_GREEN: begin
                     goal_in[1] = value;
                  end
                  REQ_GOAL_BLUE: begin
                     goal_in[2] = value;
                  end
                  REQ_STEP: begin
                     if (value != '0) begin
                        step_in = value;
                     end else begin
                        goal_in = level_ff;
                     end
                  end
                  REQ_BLINK: begin
                     on_time_in = value;
                     length_in  = index;
                     write_v    = (index == '0);
                  end
                  default: begin
                     // unknown code: no change, no driver update
                  end
               endcase
               for (int i = 0; i < NUM_CH; i++) begin
                  out_v[i] = write_v ? level_in[i] : '0;
               end
               rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, status_in, write_v,
                               out_v[2], out_v[1], out_v[0]};
               rsp_valid_in = 1'b1;
            end
         end

         S_RUN: begin
            // One restoring remainder step per cycle, tick count MSB first
            trial_v = {rem_ff, div_ff[TICK_BITS-1]};
            diff_v  = {1'b0, trial_v} - {2'b00, length_ff};
            if (!diff_v[LEVEL_BITS+1]) begin
               rem_in = diff_v[LEVEL_BITS-1:0];
            end else begin
               rem_in = trial_v[LEVEL_BITS-1:0];
            end
            div_in = div_ff << 1;

            // Fade: clamp the distance to the step, then move the level
            if (cnt_ff == CNT_BITS'(TICK_BITS - 1)) begin
               for (int i = 0; i < NUM_CH; i++) begin
                  delta_in[i] = (mag_ff[i] > step_ff) ? step_ff : mag_ff[i];
               end
            end
            if (cnt_ff == CNT_BITS'(TICK_BITS - 2)) begin
               for (int i = 0; i < NUM_CH; i++) begin
                  if (up_ff[i]) begin
                     level_in[i] = level_ff[i] + delta_ff[i];
                  end else begin
                     level_in[i] = level_ff[i] - delta_ff[i];
                  end
               end
               moved_in = (mag_ff[0] != '0) || (mag_ff[1] != '0) || (mag_ff[2] != '0);
            end

            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end

         S_DONE: begin
            // Blink phase zero shows the levels, phase at the duty blanks them
            write_v = moved_ff;
            if (length_ff != '0) begin
               if (rem_ff == '0) begin
                  write_v = 1'b1;
               end else if (rem_ff == on_time_ff) begin
                  write_v = 1'b1;
                  blank_v = 1'b1;
               end
            end
            for (int i = 0; i < NUM_CH; i++) begin
               out_v[i] = (write_v && !blank_v) ? level_ff[i] : '0;
            end
            rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, status_ff, write_v,
                            out_v[2], out_v[1], out_v[0]};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            level_ff[i] <= '0;
            goal_ff[i]  <= '0;
         end
         step_ff      <= DEFAULT_FADE_STEP;
         on_time_ff   <= '0;
         length_ff    <= '0;
         flag_ff      <= 1'b0;
         status_ff    <= 1'b0;
         tick_ff      <= '0;
         hb_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         goal_ff      <= goal_in;
         step_ff      <= step_in;
         on_time_ff   <= on_time_in;
         length_ff    <= length_in;
         flag_ff      <= flag_in;
         status_ff    <= status_in;
         tick_ff      <= tick_in;
         hb_ff        <= hb_in;
      end
   end

   // Working and output payload: no reset needed
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      delta_ff    <= delta_in;
      up_ff       <= up_in;
      moved_ff    <= moved_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

@@ design/rfb_checker.sv @@
// Port-level checker for the RGB fade and blink controller, with its bind.
`default_nettype none
`include "rgb_fade_blink_controller_defines.svh"
module rfb_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [0:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [rfb_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);
   import rfb_pkg::*;

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // Hold a stalled response word
   `RFB_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "response word changed while stalled")

   // A request word answers in the next cycle
   `RFB_ASSERT(a_req_answer, clock, reset,
      req_fire && (req_tuser[0] == OP_REQUEST) |=> rsp_tvalid,
      "request word gave no response")

   // A tick word leaves the output empty while it is worked on
   `RFB_ASSERT(a_tick_busy, clock, reset,
      req_fire && (req_tuser[0] == OP_TICK) |=> !rsp_tvalid && !req_tready,
      "tick word not held in progress")

   // Drop colour values when the driver is not updated
   `RFB_ASSERT_ALWAYS(a_no_write_dark, clock,
      rsp_tvalid && !rsp_tdata[RSP_WRITE_BIT] |-> (rsp_tdata[RSP_WRITE_BIT-1:0] == '0) || reset,
      "colour without driver update")

endmodule

bind rgb_fade_blink_controller rfb_checker u_rfb_checker (.*);
`default_nettype wire

@@ tb/sv/rgb_fade_blink_controller_tb.sv @@
// Self-checking testbench for the RGB fade and blink controller stream interface.
`default_nettype none
module rgb_fade_blink_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rfb_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_WORDS = 500;

   // One response word as the LED driver sees it
   typedef struct packed {
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic [LEVEL_BITS-1:0] blue;
      logic                  write;
      logic                  status;
   } led_word_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [0:0]                req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // Shadow of the controller state
   logic [LEVEL_BITS-1:0] red_lvl, green_lvl, blue_lvl;
   logic [LEVEL_BITS-1:0] red_tgt, green_tgt, blue_tgt;
   logic [LEVEL_BITS-1:0] step_size, duty_ticks, period_ticks;
   logic                  flag_buf, status_lit;
   logic [TICK_BITS-1:0]  ms_count;

   led_word_type expected_led_words[$];
   int        mismatches      = 0;
   int        hold_off_cycles = 0;
   int        stall_left      = 0;
   bit        tx_quiet        = 1'b0;
   bit        rx_quiet        = 1'b0;

   rgb_fade_blink_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Move a level toward its goal by no more than the fade step
   function automatic logic [LEVEL_BITS-1:0] step_toward(input logic [LEVEL_BITS-1:0] lvl,
                                                         input logic [LEVEL_BITS-1:0] tgt,
                                                         input logic [LEVEL_BITS-1:0] stp);
      logic [LEVEL_BITS-1:0] delta;
      if (lvl == tgt) return lvl;
      if (lvl < tgt) begin
         delta = tgt - lvl;
         if (delta > stp) delta = stp;
         return lvl + delta;
      end
      delta = lvl - tgt;
      if (delta > stp) delta = stp;
      return lvl - delta;
   endfunction

   function void hold_goals();
      red_tgt   = red_lvl;
      green_tgt = green_lvl;
      blue_tgt  = blue_lvl;
   endfunction

   // Advance the shadow state by one accepted word and give the response it causes
   function led_word_type next_led_word(input logic op, input logic [CODE_BITS-1:0] code,
                                        input logic [LEVEL_BITS-1:0] val,
                                        input logic [LEVEL_BITS-1:0] idx);
      led_word_type          w;
      logic [LEVEL_BITS-1:0] nr, ng, nb;
      logic [TICK_BITS-1:0]  ph;
      w = '0;
      if (op == OP_REQUEST) begin
         if (code == REQ_ALL_OFF) begin
            red_lvl   = '0;
            green_lvl = '0;
            blue_lvl  = '0;
            flag_buf  = 1'b0;
         end
         case (code)
            REQ_ALL_OFF, REQ_COMMIT: begin
               status_lit = flag_buf;
               w.write    = 1'b1;
               hold_goals();
            end
            REQ_FLAG:       flag_buf = (val != '0);
            REQ_RED: begin
               red_lvl = val;
               hold_goals();
            end
            REQ_GREEN: begin
               green_lvl = val;
               hold_goals();
            end
            REQ_BLUE: begin
               blue_lvl = val;
               hold_goals();
            end
            REQ_GOAL_RED:   red_tgt = val;
            REQ_GOAL_GREEN: green_tgt = val;
            REQ_GOAL_BLUE:  blue_tgt = val;
            REQ_STEP: begin
               if (val != '0) step_size = val;
               else hold_goals();
            end
            REQ_BLINK: begin
               duty_ticks   = val;
               period_ticks = idx;
               if (idx == '0) w.write = 1'b1;
            end
            default: ;
         endcase
         if (w.write) begin
            w.red   = red_lvl;
            w.green = green_lvl;
            w.blue  = blue_lvl;
         end
      end else begin
         ms_count  = ms_count + 1'b1;
         nr        = step_toward(red_lvl, red_tgt, step_size);
         ng        = step_toward(green_lvl, green_tgt, step_size);
         nb        = step_toward(blue_lvl, blue_tgt, step_size);
         w.write   = (nr != red_lvl) || (ng != green_lvl) || (nb != blue_lvl);
         red_lvl   = nr;
         green_lvl = ng;
         blue_lvl  = nb;
         w.red     = nr;
         w.green   = ng;
         w.blue    = nb;
         if (period_ticks != '0) begin
            ph = ms_count % TICK_BITS'(period_ticks);
            // phase zero wins over the dark phase
            if (ph == '0) begin
               w.write = 1'b1;
            end else if (ph == TICK_BITS'(duty_ticks)) begin
               w.red   = '0;
               w.green = '0;
               w.blue  = '0;
               w.write = 1'b1;
            end
         end
         ph = ms_count % TICK_BITS'(HEARTBEAT_PERIOD);
         if (ph == '0) status_lit = 1'b1;
         else if (ph == TICK_BITS'(HB_OFF_AT)) status_lit = 1'b0;
         if (!w.write) begin
            w.red   = '0;
            w.green = '0;
            w.blue  = '0;
         end
      end
      w.status = status_lit;
      return w;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 90);
   endfunction

   // Offer one word, hold it until accepted, then record what it should produce
   task send_word(input logic op, input logic [CODE_BITS-1:0] code,
                  input logic [LEVEL_BITS-1:0] val, input logic [LEVEL_BITS-1:0] idx);
      int gap;
      gap = pick_gap(tx_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {idx, val, code};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      expected_led_words.push_back(next_led_word(op, code, val, idx));
   endtask

   task send_tick();
      send_word(OP_TICK, CODE_BITS'($urandom), LEVEL_BITS'($urandom), LEVEL_BITS'($urandom));
   endtask

   task send_request(input logic [CODE_BITS-1:0] code, input logic [LEVEL_BITS-1:0] val,
                     input logic [LEVEL_BITS-1:0] idx);
      send_word(OP_REQUEST, code, val, idx);
   endtask

   // Drop valid and pause until every response has come back
   task wait_drained();
      req_tvalid <= 1'b0;
      while (expected_led_words.size() != 0) @(posedge clock);
   endtask

   task check_field(input string name, input logic [LEVEL_BITS-1:0] exp_v,
                    input logic [LEVEL_BITS-1:0] got_v);
      if (exp_v !== got_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      end
   endtask

   // Receiver: check each accepted response word, then decide whether to stall
   initial begin
      led_word_type exp_w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_led_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response word, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               exp_w = expected_led_words.pop_front();
               check_field("red_out", exp_w.red, rsp_tdata[15:0]);
               check_field("green_out", exp_w.green, rsp_tdata[31:16]);
               check_field("blue_out", exp_w.blue, rsp_tdata[47:32]);
               check_field("rgb_write", LEVEL_BITS'(exp_w.write),
                           LEVEL_BITS'(rsp_tdata[RSP_WRITE_BIT]));
               check_field("status_led", LEVEL_BITS'(exp_w.status),
                           LEVEL_BITS'(rsp_tdata[RSP_STATUS_BIT]));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap(rx_quiet);
         end
      end
   end

   // Watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb_fade_blink_controller_tb: errors");
      $finish;
   end

   task reset_shadow();
      red_lvl      = '0;
      green_lvl    = '0;
      blue_lvl     = '0;
      red_tgt      = '0;
      green_tgt    = '0;
      blue_tgt     = '0;
      step_size    = DEFAULT_FADE_STEP;
      duty_ticks   = '0;
      period_ticks = '0;
      flag_buf     = 1'b0;
      status_lit   = 1'b0;
      ms_count     = '0;
   endtask

   // Every request code, field extremes, unknown codes and the fade step
   task test_requests();
      send_request(8'd11, 16'hFFFF, 16'hFFFF);      // unknown: no update
      send_request(8'd255, 16'h0000, 16'h0000);
      send_request(REQ_FLAG, 16'hFFFF, 16'h0000);
      send_request(REQ_COMMIT, 16'h0000, 16'hFFFF);  // status takes the flag
      send_request(REQ_RED, 16'hFFFF, 16'h0000);
      send_request(REQ_GREEN, 16'h0000, 16'hFFFF);
      send_request(REQ_BLUE, 16'h8001, 16'h5AA5);
      send_request(REQ_COMMIT, 16'h0000, 16'h0000);
      send_request(REQ_GOAL_RED, 16'h0000, 16'h0000);
      send_request(REQ_GOAL_GREEN, 16'hFFFF, 16'h0000);
      send_request(REQ_GOAL_BLUE, 16'h7FFE, 16'h0000);
      send_tick();                                   // fade by the default step
      send_tick();
      send_request(REQ_STEP, 16'hFFFF, 16'h0000);
      send_tick();                                   // jump straight to the goals
      send_tick();                                   // nothing moves, no update
      send_request(REQ_GOAL_RED, 16'h1234, 16'h0000);
      send_request(REQ_STEP, 16'h0000, 16'h0000);    // zero step freezes the goals
      send_tick();
      send_request(REQ_STEP, 16'h0001, 16'h0000);
      send_request(REQ_GOAL_GREEN, 16'hFFF0, 16'h0000);
      send_tick();
      send_request(REQ_BLINK, 16'hFFFF, 16'h0000);   // blink off pushes the levels
      send_request(REQ_ALL_OFF, 16'hFFFF, 16'hFFFF);
      send_tick();
   endtask

   // Blink phases: normal duty, zero duty, duty not below period, period one
   task test_blink();
      send_request(REQ_RED, 16'h00FF, 16'h0000);
      send_request(REQ_BLUE, 16'hF000, 16'h0000);
      send_request(REQ_BLINK, 16'd2, 16'd4);
      repeat (9) send_tick();
      send_request(REQ_BLINK, 16'd0, 16'd3);
      repeat (4) send_tick();
      send_request(REQ_BLINK, 16'd7, 16'd5);
      repeat (6) send_tick();
      send_request(REQ_BLINK, 16'd3, 16'd1);
      repeat (3) send_tick();
      send_request(REQ_BLINK, 16'hFFFF, 16'hFFFF);
      repeat (2) send_tick();
      send_request(REQ_BLINK, 16'd0, 16'd0);
   endtask

   // Long receiver hold while words keep coming, then a full drain
   task test_backpressure();
      wait_drained();
      tx_quiet        = 1'b1;
      hold_off_cycles = 300;
      repeat (12) begin
         send_request(REQ_GOAL_RED, LEVEL_BITS'($urandom), 16'h0000);
         send_tick();
         send_request(REQ_FLAG, LEVEL_BITS'($urandom_range(0, 1)), 16'h0000);
      end
      tx_quiet = 1'b0;
      wait_drained();
   endtask

   // Random mix of ticks and requests with random content
   task test_random_mix();
      int                    r;
      logic [CODE_BITS-1:0]  code;
      logic [LEVEL_BITS-1:0] val, idx;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 60 == 0) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
         end
         r   = $urandom_range(0, 99);
         val = LEVEL_BITS'($urandom);
         idx = LEVEL_BITS'($urandom);
         if (r < 55) begin
            send_tick();
         end else if (r < 60) begin
            send_request(CODE_BITS'($urandom_range(11, 255)), val, idx);
         end else begin
            code = CODE_BITS'($urandom_range(0, 10));
            case (code)
               REQ_STEP: begin
                  if ($urandom_range(0, 9) < 7) val = LEVEL_BITS'($urandom_range(0, 3000));
               end
               REQ_BLINK: begin
                  r = $urandom_range(0, 9);
                  if (r < 2) idx = '0;
                  else if (r < 9) idx = LEVEL_BITS'($urandom_range(1, 12));
                  if ($urandom_range(0, 9) < 8)
                     val = LEVEL_BITS'($urandom_range(0, int'(idx) + 2));
               end
               REQ_FLAG: begin
                  if ($urandom_range(0, 1) == 0) val = '0;
               end
               default: begin
                  r = $urandom_range(0, 9);
                  if (r == 0) val = '0;
                  else if (r == 1) val = '1;
               end
            endcase
            send_request(code, val, idx);
         end
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   // Tick past the first heartbeat so the status LED lights and goes dark again
   task test_heartbeat();
      send_request(REQ_BLINK, 16'd1, 16'd7);
      while (ms_count < TICK_BITS'(HEARTBEAT_PERIOD + 12)) send_tick();
      send_request(REQ_FLAG, 16'h0001, 16'h0000);
      send_request(REQ_COMMIT, 16'h0000, 16'h0000);
      send_tick();
   endtask

   initial begin
      reset_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_requests();
      test_blink();
      test_backpressure();
      test_random_mix();
      test_heartbeat();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_led_words.size() == 0)
         $display("rgb_fade_blink_controller_tb: clean");
      else
         $display("rgb_fade_blink_controller_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire
